[rtl/core/ialu_pkg.sv]
// package: function codes, constants and shared types of the integer alu
package ialu_pkg;

    localparam int WordBits = 32;
    localparam int HalfBits = 16;
    localparam int FuncBits = 4;
    localparam int ShiftBits = $clog2(WordBits);

    localparam logic [WordBits-1:0] MaskHighHalf = 32'hFFFF_0000;
    localparam logic [WordBits-1:0] MaskLowHalf  = 32'h0000_FFFF;

    typedef enum logic [FuncBits-1:0] {
        FUNC_AND   = 4'd0,
        FUNC_ADD   = 4'd1,
        FUNC_ADDU  = 4'd2,
        FUNC_SUB   = 4'd3,
        FUNC_MOV   = 4'd4,
        FUNC_OR    = 4'd5,
        FUNC_XOR   = 4'd6,
        FUNC_SRL   = 4'd7,
        FUNC_SLL   = 4'd8,
        FUNC_SRA   = 4'd9,
        FUNC_MOVLO = 4'd10,
        FUNC_MOVHI = 4'd11,
        FUNC_EQ    = 4'd12,
        FUNC_NE    = 4'd13,
        FUNC_GT    = 4'd14,
        FUNC_LE    = 4'd15
    } func_t;

    typedef struct packed {
        logic [WordBits-1:0] result;
        logic                set_carry;
        logic                set_overflow;
    } exec_res_t;

endpackage

[rtl/core/ialu_op_if.sv]
// interface: operation channel (function code and two operands)
interface ialu_op_if
    import ialu_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [FuncBits-1:0]        func;
    logic signed [WordBits-1:0] operand_a;
    logic signed [WordBits-1:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

[rtl/core/ialu_res_if.sv]
// interface: result channel (value and flags)
interface ialu_res_if
    import ialu_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [WordBits-1:0] result_value;
    logic                       negative_flag;
    logic                       zero_flag;
    logic                       carry_flag;
    logic                       overflow_flag;

    modport source (output valid, output result_value, output negative_flag,
                    output zero_flag, output carry_flag, output overflow_flag,
                    input ready);
    modport sink   (input valid, input result_value, input negative_flag,
                    input zero_flag, input carry_flag, input overflow_flag,
                    output ready);
endinterface

[rtl/core/ialu_exec.sv]
// combinational execute logic: result and sticky flag set conditions
module ialu_exec
    import ialu_pkg::*;
(
    input  logic [FuncBits-1:0] func,
    input  logic [WordBits-1:0] operand_a,
    input  logic [WordBits-1:0] operand_b,
    output exec_res_t           res
);

    logic [WordBits:0]       sum_ext;
    logic [WordBits-1:0]     sum;
    logic [WordBits-1:0]     diff;
    logic [ShiftBits-1:0]    shamt;
    logic                    shift_big;
    logic [2*WordBits-1:0]   sll_ext;
    logic [WordBits-1:0]     srl_val;
    logic [WordBits-1:0]     sra_val;
    logic                    add_ovf;
    logic                    sll_lost;
    logic                    lt_signed;
    logic                    eq_val;

    always_comb
    begin
        sum_ext   = {1'b0, operand_a} + {1'b0, operand_b};
        sum       = sum_ext[WordBits-1:0];
        diff      = operand_a - operand_b;
        shamt     = operand_b[ShiftBits-1:0];
        shift_big = |operand_b[WordBits-1:ShiftBits];
        sll_ext   = {{WordBits{1'b0}}, operand_a} << shamt;
        srl_val   = operand_a >> shamt;
        sra_val   = WordBits'($signed(operand_a) >>> shamt);
        add_ovf   = (operand_a[WordBits-1] == operand_b[WordBits-1])
                    && (sum[WordBits-1] != operand_a[WordBits-1]);
        sll_lost  = shift_big ? (|operand_a) : (|sll_ext[2*WordBits-1:WordBits]);
        lt_signed = $signed(operand_a) < $signed(operand_b);
        eq_val    = operand_a == operand_b;

        res.result       = '0;
        res.set_carry    = 1'b0;
        res.set_overflow = 1'b0;

        case (func_t'(func))
            FUNC_AND:   res.result = operand_a & operand_b;
            FUNC_ADD:
            begin
                res.result    = sum;
                res.set_carry = add_ovf;
            end
            FUNC_ADDU:
            begin
                res.result    = sum;
                res.set_carry = sum_ext[WordBits];
            end
            FUNC_SUB:   res.result = diff;
            FUNC_MOV:   res.result = operand_a;
            FUNC_OR:    res.result = operand_a | operand_b;
            FUNC_XOR:   res.result = operand_a ^ operand_b;
            FUNC_SRL:   res.result = shift_big ? '0 : srl_val;
            FUNC_SLL:
            begin
                res.result       = shift_big ? '0 : sll_ext[WordBits-1:0];
                res.set_carry    = sll_lost;
                res.set_overflow = sll_lost;
            end
            FUNC_SRA:   res.result = shift_big ? {WordBits{operand_a[WordBits-1]}} : sra_val;
            FUNC_MOVLO: res.result = (operand_a & MaskHighHalf) | (operand_b & MaskLowHalf);
            FUNC_MOVHI: res.result = (operand_a & MaskLowHalf)
                                     | {operand_b[HalfBits-1:0], {HalfBits{1'b0}}};
            FUNC_EQ:    res.result = {{(WordBits-1){1'b0}}, eq_val};
            FUNC_NE:    res.result = {{(WordBits-1){1'b0}}, !eq_val};
            FUNC_GT:    res.result = {{(WordBits-1){1'b0}}, !lt_signed && !eq_val};
            FUNC_LE:    res.result = {{(WordBits-1){1'b0}}, lt_signed || eq_val};
            default:    res.result = '0;
        endcase
    end

endmodule

[rtl/core/int_alu_with_flags.sv]
// 32-bit integer alu with n/z flags and sticky carry/overflow flags
// an operation passes the operand register and then the result register before its result is offered
// throughput: one operation per cycle while results are not stalled, set by the operand and result registers
// a stalled result holds its register while the operand register still accepts one more
// reset clears both valid bits and the sticky carry and overflow flags
module int_alu_with_flags
    import ialu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ialu_op_if.sink     op,
    ialu_res_if.source  res
);

    logic                s1_valid_reg;
    logic [FuncBits-1:0] func_reg;
    logic [WordBits-1:0] a_reg;
    logic [WordBits-1:0] b_reg;

    logic                out_valid_reg;
    logic [WordBits-1:0] result_reg;
    logic                carry_out_reg;
    logic                overflow_out_reg;

    logic                carry_reg;
    logic                carry_next;
    logic                overflow_reg;
    logic                overflow_next;

    exec_res_t           ex;
    logic                advance;
    logic                op_xfer;

    ialu_exec u_exec (
        .func      (func_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .res       (ex)
    );

    assign advance       = s1_valid_reg && (!out_valid_reg || res.ready);
    assign op.ready      = !s1_valid_reg || advance;
    assign op_xfer       = op.valid && op.ready;
    assign carry_next    = carry_reg | ex.set_carry;
    assign overflow_next = overflow_reg | ex.set_overflow;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            carry_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (op.ready)
            begin
                s1_valid_reg <= op.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                carry_reg     <= carry_next;
                overflow_reg  <= overflow_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_xfer)
        begin
            func_reg <= op.func;
            a_reg    <= op.operand_a;
            b_reg    <= op.operand_b;
        end
        if (advance)
        begin
            result_reg       <= ex.result;
            carry_out_reg    <= carry_next;
            overflow_out_reg <= overflow_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.result_value  = result_reg;
    assign res.negative_flag = result_reg[WordBits-1];
    assign res.zero_flag     = result_reg == '0;
    assign res.carry_flag    = carry_out_reg;
    assign res.overflow_flag = overflow_out_reg;

endmodule

[tb/tb.sv]
// testbench for int_alu_with_flags: directed and random operations checked against a built-in predictor
module tb;
    import ialu_pkg::*;

    localparam int RandomOps  = 1050;
    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 8;

    typedef struct {
        func_t             func;
        logic [WordBits-1:0] a;
        logic [WordBits-1:0] b;
        int unsigned       gap;
    } alu_op_t;

    typedef struct packed {
        logic [WordBits-1:0] value;
        logic                negative;
        logic                zero;
        logic                carry;
        logic                overflow;
    } alu_out_t;

    logic clk = 1'b0;
    logic rst_n;

    ialu_op_if  op_ch();
    ialu_res_if res_ch();

    int_alu_with_flags dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch.sink),
        .res   (res_ch.source)
    );

    alu_op_t  pending_ops[$];
    alu_out_t awaited_results[$];

    logic        sticky_c = 1'b0;
    logic        sticky_v = 1'b0;
    logic        op_fire  = 1'b0;
    logic        res_fire = 1'b0;
    logic        op_busy  = 1'b0;
    int unsigned op_wait  = 0;
    int unsigned res_stall = 0;
    int          cycle_count = 0;
    int          ops_sent = 0;
    int          results_checked = 0;
    int          errors = 0;
    int          func_count[16];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic alu_out_t alu_compute(input func_t f, input logic [WordBits-1:0] a,
                                             input logic [WordBits-1:0] b);
        logic [WordBits-1:0]   r;
        logic [WordBits:0]     wide_sum;
        logic [2*WordBits-1:0] wide_shift;
        alu_out_t              o;
        r = '0;
        case (f)
            FUNC_AND: r = a & b;
            FUNC_ADD:
            begin
                r = a + b;
                if (a[WordBits-1] == b[WordBits-1] && r[WordBits-1] != a[WordBits-1])
                    sticky_c = 1'b1;
            end
            FUNC_ADDU:
            begin
                wide_sum = {1'b0, a} + {1'b0, b};
                r = wide_sum[WordBits-1:0];
                if (wide_sum[WordBits])
                    sticky_c = 1'b1;
            end
            FUNC_SUB: r = a - b;
            FUNC_MOV: r = a;
            FUNC_OR:  r = a | b;
            FUNC_XOR: r = a ^ b;
            FUNC_SRL: r = (b >= WordBits) ? '0 : (a >> b[ShiftBits-1:0]);
            FUNC_SLL:
            begin
                if (b >= WordBits)
                begin
                    r = '0;
                    wide_shift = {a, {WordBits{1'b0}}};
                end
                else
                begin
                    wide_shift = {{WordBits{1'b0}}, a} << b[ShiftBits-1:0];
                    r = wide_shift[WordBits-1:0];
                end
                // set bits pushed past bit 31
                if (wide_shift[2*WordBits-1:WordBits] != '0)
                begin
                    sticky_c = 1'b1;
                    sticky_v = 1'b1;
                end
            end
            FUNC_SRA:
            begin
                if (b >= WordBits)
                    r = {WordBits{a[WordBits-1]}};
                else
                    r = $signed(a) >>> b[ShiftBits-1:0];
            end
            FUNC_MOVLO: r = (a & MaskHighHalf) | (b & MaskLowHalf);
            FUNC_MOVHI: r = (a & MaskLowHalf) | ((b & MaskLowHalf) << HalfBits);
            FUNC_EQ: r = (a == b) ? 1 : 0;
            FUNC_NE: r = (a != b) ? 1 : 0;
            FUNC_GT: r = ($signed(a) > $signed(b)) ? 1 : 0;
            FUNC_LE: r = ($signed(a) <= $signed(b)) ? 1 : 0;
            default: r = '0;
        endcase
        o.value    = r;
        o.negative = r[WordBits-1];
        o.zero     = (r == '0);
        o.carry    = sticky_c;
        o.overflow = sticky_v;
        return o;
    endfunction

    function automatic logic [WordBits-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input func_t f, input logic [WordBits-1:0] a,
                          input logic [WordBits-1:0] b, input int unsigned gap);
        alu_op_t item;
        item.func = f;
        item.a    = a;
        item.b    = b;
        item.gap  = gap;
        pending_ops.push_back(item);
    endtask

    // operation driver
    always @(negedge clk)
    begin
        alu_op_t item;
        if (rst_n)
        begin
            if (op_fire)
                op_busy = 1'b0;
            if (!op_busy)
            begin
                if (op_wait > 0)
                    op_wait = op_wait - 1;
                else if (pending_ops.size() > 0)
                begin
                    item = pending_ops.pop_front();
                    op_ch.func      <= item.func;
                    op_ch.operand_a <= item.a;
                    op_ch.operand_b <= item.b;
                    op_wait = item.gap;
                    op_busy = 1'b1;
                end
            end
            op_ch.valid <= op_busy;
        end
    end

    // result receiver with phased stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_fire)
            begin
                case ((results_checked / 128) % 3)
                    0: res_stall = $urandom_range(0, 9);
                    1: res_stall = 0;
                    default: res_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
                endcase
            end
            if (res_stall > 0)
            begin
                res_stall = res_stall - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // transfer monitor, checker and predictor
    always @(posedge clk)
    begin
        alu_out_t got;
        alu_out_t want;
        op_fire  <= rst_n && op_ch.valid && op_ch.ready;
        res_fire <= rst_n && res_ch.valid && res_ch.ready;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.value    = res_ch.result_value;
                got.negative = res_ch.negative_flag;
                got.zero     = res_ch.zero_flag;
                got.carry    = res_ch.carry_flag;
                got.overflow = res_ch.overflow_flag;
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual value=%h n=%b z=%b c=%b v=%b",
                             $time, got.value, got.negative, got.zero, got.carry, got.overflow);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected value=%h n=%b z=%b c=%b v=%b, actual value=%h n=%b z=%b c=%b v=%b",
                                 $time, want.value, want.negative, want.zero, want.carry,
                                 want.overflow, got.value, got.negative, got.zero, got.carry,
                                 got.overflow);
                        errors++;
                    end
                end
                results_checked++;
            end
            if (op_ch.valid && op_ch.ready)
            begin
                awaited_results.push_back(alu_compute(func_t'(op_ch.func), op_ch.operand_a,
                                                      op_ch.operand_b));
                func_count[op_ch.func]++;
                ops_sent++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CycleLimit)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 awaited_results.size());
        $display("int_alu_with_flags: mismatch");
        $finish;
    end

    initial
    begin
        func_t       f;
        logic [WordBits-1:0] a;
        logic [WordBits-1:0] b;
        int unsigned gap;
        int          funcs_hit;

        rst_n           = 1'b0;
        op_ch.valid     = 1'b0;
        op_ch.func      = FUNC_AND;
        op_ch.operand_a = '0;
        op_ch.operand_b = '0;
        res_ch.ready    = 1'b0;
        foreach (func_count[i])
            func_count[i] = 0;

        // every function on extremes, sticky flags still clear
        add_op(FUNC_AND,   32'hFFFF_FFFF, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_OR,    32'h0000_0000, 32'h0000_0000, $urandom_range(0, 9));
        add_op(FUNC_XOR,   32'hAAAA_AAAA, 32'h5555_5555, $urandom_range(0, 9));
        add_op(FUNC_ADD,   32'h7FFF_FFFE, 32'h0000_0001, $urandom_range(0, 9));
        add_op(FUNC_ADDU,  32'hFFFF_FFFE, 32'h0000_0001, $urandom_range(0, 9));
        add_op(FUNC_SUB,   32'h8000_0000, 32'h0000_0001, $urandom_range(0, 9));
        add_op(FUNC_SUB,   32'h0000_0000, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_MOV,   32'h8000_0000, 32'h1234_5678, $urandom_range(0, 9));
        add_op(FUNC_SRL,   32'h8000_0000, 32'd31,        $urandom_range(0, 9));
        add_op(FUNC_SRL,   32'hFFFF_FFFF, 32'd32,        $urandom_range(0, 9));
        add_op(FUNC_SRA,   32'h8000_0000, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_op(FUNC_SRA,   32'h7FFF_FFFF, 32'd40,        $urandom_range(0, 9));
        add_op(FUNC_SRA,   32'h8000_0001, 32'd0,         $urandom_range(0, 9));
        add_op(FUNC_SLL,   32'h0000_0001, 32'd31,        $urandom_range(0, 9));
        add_op(FUNC_SLL,   32'h0000_0000, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_op(FUNC_SLL,   32'hFFFF_FFFF, 32'd0,         $urandom_range(0, 9));
        add_op(FUNC_MOVLO, 32'hFFFF_FFFF, 32'h0000_0000, $urandom_range(0, 9));
        add_op(FUNC_MOVHI, 32'h0000_FFFF, 32'hFFFF_8000, $urandom_range(0, 9));
        add_op(FUNC_EQ,    32'h8000_0000, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_NE,    32'h7FFF_FFFF, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_GT,    32'h7FFF_FFFF, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_LE,    32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(0, 9));

        // first sticky flag setter picked at random
        case ($urandom_range(0, 4))
            0: add_op(FUNC_ADD,  32'h7FFF_FFFF, 32'h0000_0001, $urandom_range(0, 9));
            1: add_op(FUNC_ADD,  32'h8000_0000, 32'hFFFF_FFFF, $urandom_range(0, 9));
            2: add_op(FUNC_ADDU, 32'hFFFF_FFFF, 32'h0000_0001, $urandom_range(0, 9));
            3: add_op(FUNC_SLL,  32'h8000_0001, 32'd1,         $urandom_range(0, 9));
            default: add_op(FUNC_SLL, 32'h0000_0001, 32'd32,   $urandom_range(0, 9));
        endcase
        add_op(FUNC_ADD,  32'h8000_0000, 32'h8000_0000, $urandom_range(0, 9));
        add_op(FUNC_SLL,  32'h0001_0000, 32'hFFFF_FFFF, $urandom_range(0, 9));

        for (int i = 0; i < RandomOps; i++)
        begin
            f = func_t'($urandom_range(0, 15));
            a = rand_word();
            b = rand_word();
            if (f inside {FUNC_SRL, FUNC_SLL, FUNC_SRA} && $urandom_range(0, 3) != 0)
                b = $urandom_range(0, 40);
            else if (f inside {FUNC_EQ, FUNC_NE, FUNC_GT, FUNC_LE} && $urandom_range(0, 2) == 0)
                b = a;
            case ((i / 100) % 3)
                0: gap = $urandom_range(0, 9);
                1: gap = 0;
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
            endcase
            add_op(f, a, b, gap);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || op_busy || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        funcs_hit = 0;
        foreach (func_count[i])
            if (func_count[i] > 0)
                funcs_hit++;
        $display("%0d operations sent, %0d results checked, %0d of 16 function codes used",
                 ops_sent, results_checked, funcs_hit);
        $display("sticky carry reached %b, sticky overflow reached %b, %0d errors",
                 sticky_c, sticky_v, errors);
        if (errors == 0)
            $display("int_alu_with_flags: match");
        else
            $display("int_alu_with_flags: mismatch");
        $finish;
    end

endmodule

[int_alu_with_flags.f]
rtl/core/ialu_pkg.sv
rtl/core/ialu_op_if.sv
rtl/core/ialu_res_if.sv
rtl/core/ialu_exec.sv
rtl/core/int_alu_with_flags.sv
tb/tb.sv
